>>> src/lacb_pkg.sv
// ----------------------------------------------------------------------------
// lacb_pkg: shared types, constants and helpers of the look-at camera basis
// Holds default widths, the block-scaling target width, the control and
// status structs of the normalization unit and the leading-one search.
// ----------------------------------------------------------------------------
package lacb_pkg;

    localparam int LACB_COORD_WIDTH    = 32;
    localparam int LACB_UNIT_FRAC_BITS = 14;
    localparam int LACB_OUT_W          = 16;
    localparam int LACB_NORM_W         = 30;
    localparam int LACB_LEAD_W         = 7;

    typedef struct packed {
        logic en;
        logic valid;
    } t_norm_ctl;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_norm_stat;

    function automatic logic [LACB_LEAD_W-1:0] f_lead(input logic [63:0] v);
        logic [LACB_LEAD_W-1:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = LACB_LEAD_W'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> src/lacb_ifs.sv
// ----------------------------------------------------------------------------
// lacb_ifs: request and result channels of the look-at camera basis
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface lacb_in_if #(
    parameter int COORD_W = lacb_pkg::LACB_COORD_WIDTH
);
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] upref_x;
    logic signed [COORD_W-1:0] upref_y;
    logic signed [COORD_W-1:0] upref_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               upref_x, upref_y, upref_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               upref_x, upref_y, upref_z,
        output ready
    );
endinterface

interface lacb_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] fwd_x;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] fwd_y;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] fwd_z;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] side_x;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] side_y;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] side_z;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] camup_x;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] camup_y;
    logic signed [lacb_pkg::LACB_OUT_W-1:0] camup_z;
    logic                                   degenerate;

    modport source (
        output valid, fwd_x, fwd_y, fwd_z, side_x, side_y, side_z,
               camup_x, camup_y, camup_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, fwd_x, fwd_y, fwd_z, side_x, side_y, side_z,
               camup_x, camup_y, camup_z, degenerate,
        output ready
    );
endinterface

>>> src/lacb_norm.sv
// ----------------------------------------------------------------------------
// lacb_norm: pipelined vector normalization
// Block scales a 3-vector to 30-bit magnitudes, squares and sums them, takes
// the integer square root one bit per stage and divides each component by
// the length one quotient bit per stage. Side data travels with each item.
// ----------------------------------------------------------------------------
module lacb_norm #(
    parameter int IN_W   = 33,
    parameter int FRAC_W = lacb_pkg::LACB_UNIT_FRAC_BITS,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lacb_pkg::t_norm_ctl       i_ctl,
    input  logic signed [IN_W-1:0]    i_vec [3],
    input  logic [SIDE_W-1:0]         i_side,
    output lacb_pkg::t_norm_stat      o_stat,
    output logic signed [FRAC_W+1:0]  o_vec [3],
    output logic [SIDE_W-1:0]         o_side
);
    import lacb_pkg::*;

    localparam int SW    = LACB_NORM_W;
    localparam int SQW   = 2 * SW + 2;
    localparam int RTW   = SW + 1;
    localparam int REMW  = RTW + 3;
    localparam int QW    = FRAC_W + 1;
    localparam int NUMW  = SW + FRAC_W + 1;
    localparam int DREMW = RTW + 1;

    logic                   en;
    logic [IN_W-1:0]        n_a_mag [3];

    logic                   r_a_vld;
    logic [IN_W-1:0]        r_a_mag [3];
    logic [2:0]             r_a_sgn;
    logic [LACB_LEAD_W-1:0] r_a_lead;
    logic                   r_a_nz;
    logic [SIDE_W-1:0]      r_a_side;

    logic [7:0]             b_sh;
    logic [IN_W+SW-1:0]     b_tmp [3];
    logic                   r_b_vld;
    logic [SW-1:0]          r_b_r [3];
    logic [2:0]             r_b_sgn;
    logic                   r_b_nz;
    logic [SIDE_W-1:0]      r_b_side;

    logic                   r_c_vld;
    logic [2*SW-1:0]        r_c_sq [3];
    logic [SW-1:0]          r_c_r [3];
    logic [2:0]             r_c_sgn;
    logic                   r_c_nz;
    logic [SIDE_W-1:0]      r_c_side;

    logic                   r_sq_vld  [RTW+1];
    logic [SQW-1:0]         r_sq_x    [RTW+1];
    logic [REMW-1:0]        r_sq_rem  [RTW+1];
    logic [RTW-1:0]         r_sq_root [RTW+1];
    logic [SW-1:0]          r_sq_r    [RTW+1][3];
    logic [2:0]             r_sq_sgn  [RTW+1];
    logic                   r_sq_nz   [RTW+1];
    logic [SIDE_W-1:0]      r_sq_side [RTW+1];

    logic                   r_dv_vld  [QW+1];
    logic [NUMW-1:0]        r_dv_num  [QW+1][3];
    logic [DREMW-1:0]       r_dv_rem  [QW+1][3];
    logic [QW-1:0]          r_dv_q    [QW+1][3];
    logic [RTW-1:0]         r_dv_len  [QW+1];
    logic [2:0]             r_dv_sgn  [QW+1];
    logic                   r_dv_nz   [QW+1];
    logic [SIDE_W-1:0]      r_dv_side [QW+1];

    logic [RTW-1:0]         e_len;
    logic [NUMW-1:0]        e_num [3];
    logic [QW-1:0]          o_q   [3];

    assign en = i_ctl.en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a_mag[k] = i_vec[k][IN_W-1] ? IN_W'(-i_vec[k]) : IN_W'(i_vec[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_ctl.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_sq_vld[0] <= r_c_vld;
            r_dv_vld[0] <= r_sq_vld[RTW];
        end
    end

    assign b_sh = 8'(r_a_lead) + 8'd1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b_tmp[k] = {r_a_mag[k], {SW{1'b0}}} >> b_sh;
        end
    end

    assign e_len = r_sq_root[RTW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_num[k] = (NUMW'(r_sq_r[RTW][k]) << FRAC_W) + NUMW'(e_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_mag[k] <= n_a_mag[k];
                r_a_sgn[k] <= i_vec[k][IN_W-1];
                r_b_r[k]   <= b_tmp[k][SW-1:0];
                r_c_sq[k]  <= r_b_r[k] * r_b_r[k];
                r_c_r[k]   <= r_b_r[k];
                r_sq_r[0][k] <= r_c_r[k];
                r_dv_num[0][k] <= e_num[k];
                r_dv_rem[0][k] <= DREMW'(e_num[k] >> QW);
                r_dv_q[0][k]   <= '0;
            end
            r_a_lead <= f_lead(64'(n_a_mag[0] | n_a_mag[1] | n_a_mag[2]));
            r_a_nz   <= |(n_a_mag[0] | n_a_mag[1] | n_a_mag[2]);
            r_a_side <= i_side;
            r_b_sgn  <= r_a_sgn;
            r_b_nz   <= r_a_nz;
            r_b_side <= r_a_side;
            r_c_sgn  <= r_b_sgn;
            r_c_nz   <= r_b_nz;
            r_c_side <= r_b_side;
            r_sq_x[0]    <= SQW'(r_c_sq[0]) + SQW'(r_c_sq[1]) + SQW'(r_c_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_sgn[0]  <= r_c_sgn;
            r_sq_nz[0]   <= r_c_nz;
            r_sq_side[0] <= r_c_side;
            r_dv_len[0]  <= e_len;
            r_dv_sgn[0]  <= r_sq_sgn[RTW];
            r_dv_nz[0]   <= r_sq_nz[RTW];
            r_dv_side[0] <= r_sq_side[RTW];
        end
    end

    for (genvar j = 0; j < RTW; j++) begin : g_sqrt
        localparam int BI = RTW - 1 - j;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        assign rem_sh = {r_sq_rem[j][REMW-3:0], r_sq_x[j][2*BI+1 -: 2]};
        assign trial  = REMW'({r_sq_root[j], 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[j+1]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[j+1] <= {r_sq_root[j][RTW-2:0], ge};
                r_sq_x[j+1]    <= r_sq_x[j];
                r_sq_r[j+1]    <= r_sq_r[j];
                r_sq_sgn[j+1]  <= r_sq_sgn[j];
                r_sq_nz[j+1]   <= r_sq_nz[j];
                r_sq_side[j+1] <= r_sq_side[j];
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int BI = QW - 1 - j;
        logic [DREMW-1:0] rem_sh [3];
        logic [2:0]       ge;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                rem_sh[k] = {r_dv_rem[j][k][DREMW-2:0], r_dv_num[j][k][BI]};
                ge[k]     = rem_sh[k] >= DREMW'(r_dv_len[j]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    r_dv_rem[j+1][k] <= ge[k] ? rem_sh[k] - DREMW'(r_dv_len[j]) : rem_sh[k];
                    r_dv_q[j+1][k]   <= {r_dv_q[j][k][QW-2:0], ge[k]};
                end
                r_dv_num[j+1]  <= r_dv_num[j];
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_sgn[j+1]  <= r_dv_sgn[j];
                r_dv_nz[j+1]   <= r_dv_nz[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_q[k] = (r_dv_q[QW][k] > (QW'(1) << FRAC_W)) ? (QW'(1) << FRAC_W)
                                                          : r_dv_q[QW][k];
            o_vec[k] = r_dv_sgn[QW][k] ? -$signed({1'b0, o_q[k]}) : $signed({1'b0, o_q[k]});
        end
        o_stat.valid = r_dv_vld[QW];
        o_stat.ok    = r_dv_nz[QW];
    end

    assign o_side = r_dv_side[QW];

endmodule

>>> src/look_at_camera_basis.sv
// ----------------------------------------------------------------------------
// look_at_camera_basis: orthonormal basis of a look-at camera
// Forward = normalize(target - eye), side = normalize(forward x up),
// camera up = side x forward, all as signed unit vectors.
//
//   Channel  Dir  Content
//   i_req    in   eye, target, reference up (COORD_WIDTH-bit signed each)
//   o_res    out  forward, side, camera up (16-bit signed), degenerate flag
//
// One request enters per cycle while o_res does not stall; the pipeline
// holds two normalization units, each with one square-root stage per root
// bit and one divider stage per quotient bit.
// Reset clears only the valid bits of the pipeline.
// A stall on o_res freezes the whole pipeline, which holds all requests.
// ----------------------------------------------------------------------------
module look_at_camera_basis #(
    parameter int COORD_WIDTH    = lacb_pkg::LACB_COORD_WIDTH,
    parameter int UNIT_FRAC_BITS = lacb_pkg::LACB_UNIT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lacb_in_if.sink     i_req,
    lacb_out_if.source  o_res
);
    import lacb_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int F      = UNIT_FRAC_BITS;
    localparam int PRE    = (CW > 62) ? CW - 62 : 0;
    localparam int EW     = CW - PRE;
    localparam int DW     = EW + 1;
    localparam int UW     = LACB_NORM_W + 1;
    localparam int VW     = F + 2;
    localparam int P1W    = VW + UW;
    localparam int XW     = F + 32;
    localparam int P2W    = 2 * VW;
    localparam int PW     = 2 * F + 3;
    localparam int OW     = LACB_OUT_W;
    localparam int SIDE1W = 1 + 3 * UW;
    localparam int SIDE2W = 1 + 3 * VW;

    logic                   en;
    logic signed [CW-1:0]   eye [3];
    logic signed [CW-1:0]   tgt [3];
    logic signed [CW-1:0]   upr [3];
    logic [CW-1:0]          n_umag [3];

    logic                   r0_valid;
    logic signed [DW-1:0]   r0_d [3];
    logic [CW-1:0]          r0_umag [3];
    logic [2:0]             r0_usgn;
    logic [LACB_LEAD_W-1:0] r0_ulead;
    logic                   r0_unz;

    logic [7:0]             s1_sh;
    logic [CW+LACB_NORM_W-1:0] s1_tmp [3];
    logic                   r1_valid;
    logic signed [DW-1:0]   r1_d [3];
    logic signed [UW-1:0]   r1_ups [3];
    logic                   r1_upok;

    t_norm_ctl              n1_ctl;
    t_norm_stat             n1_stat;
    logic signed [VW-1:0]   n1_vec [3];
    logic [SIDE1W-1:0]      n1_side_in;
    logic [SIDE1W-1:0]      n1_side;
    logic signed [UW-1:0]   n1_ups [3];

    logic                   r2_valid;
    logic                   r2_ok;
    logic signed [P1W-1:0]  r2_prod [6];
    logic signed [VW-1:0]   r2_v [3];

    logic                   r3_valid;
    logic                   r3_ok;
    logic signed [XW-1:0]   r3_c [3];
    logic signed [VW-1:0]   r3_v [3];

    t_norm_ctl              n2_ctl;
    t_norm_stat             n2_stat;
    logic signed [VW-1:0]   n2_vec [3];
    logic [SIDE2W-1:0]      n2_side_in;
    logic [SIDE2W-1:0]      n2_side;
    logic signed [VW-1:0]   n2_v [3];

    logic                   r4_valid;
    logic                   r4_ok;
    logic signed [P2W-1:0]  r4_prod [6];
    logic signed [VW-1:0]   r4_v [3];
    logic signed [VW-1:0]   r4_s [3];

    logic                   r5_valid;
    logic                   r5_ok;
    logic signed [PW-1:0]   r5_p [3];
    logic signed [VW-1:0]   r5_v [3];
    logic signed [VW-1:0]   r5_s [3];

    logic [PW-1:0]          o_pm [3];
    logic [PW-1:0]          o_pr [3];
    logic signed [VW-1:0]   o_u  [3];
    logic signed [VW+OW-1:0] o_ev [3];
    logic signed [VW+OW-1:0] o_es [3];
    logic signed [VW+OW-1:0] o_eu [3];

    logic                   r_out_valid;
    logic signed [OW-1:0]   r_fwd   [3];
    logic signed [OW-1:0]   r_side  [3];
    logic signed [OW-1:0]   r_camup [3];
    logic                   r_degen;

    assign en          = !r_out_valid || o_res.ready;
    assign i_req.ready = en;

    assign eye = '{i_req.eye_x, i_req.eye_y, i_req.eye_z};
    assign tgt = '{i_req.target_x, i_req.target_y, i_req.target_z};
    assign upr = '{i_req.upref_x, i_req.upref_y, i_req.upref_z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_umag[k] = upr[k][CW-1] ? CW'(-upr[k]) : CW'(upr[k]);
        end
    end

    assign s1_sh = 8'(r0_ulead) + 8'd1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s1_tmp[k] = {r0_umag[k], {LACB_NORM_W{1'b0}}} >> s1_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r0_valid    <= i_req.valid;
            r1_valid    <= r0_valid;
            r2_valid    <= n1_stat.valid;
            r3_valid    <= r2_valid;
            r4_valid    <= n2_stat.valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r0_d[k]    <= DW'(EW'(tgt[k] >>> PRE)) - DW'(EW'(eye[k] >>> PRE));
                r0_umag[k] <= n_umag[k];
                r0_usgn[k] <= upr[k][CW-1];
                r1_d[k]    <= r0_d[k];
                r1_ups[k]  <= r0_usgn[k] ? -$signed({1'b0, s1_tmp[k][LACB_NORM_W-1:0]})
                                         : $signed({1'b0, s1_tmp[k][LACB_NORM_W-1:0]});
            end
            r0_ulead <= f_lead(64'(n_umag[0] | n_umag[1] | n_umag[2]));
            r0_unz   <= |(n_umag[0] | n_umag[1] | n_umag[2]);
            r1_upok  <= r0_unz;
        end
    end

    always_comb begin
        n1_ctl.en    = en;
        n1_ctl.valid = r1_valid;
        n1_side_in   = {r1_upok, r1_ups[2], r1_ups[1], r1_ups[0]};
        for (int k = 0; k < 3; k++) begin
            n1_ups[k] = $signed(n1_side[UW*k +: UW]);
        end
    end

    lacb_norm #(
        .IN_W   (DW),
        .FRAC_W (F),
        .SIDE_W (SIDE1W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n1_ctl),
        .i_vec   (r1_d),
        .i_side  (n1_side_in),
        .o_stat  (n1_stat),
        .o_vec   (n1_vec),
        .o_side  (n1_side)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok      <= n1_stat.ok && n1_side[SIDE1W-1];
            r2_prod[0] <= n1_vec[1] * n1_ups[2];
            r2_prod[1] <= n1_vec[2] * n1_ups[1];
            r2_prod[2] <= n1_vec[2] * n1_ups[0];
            r2_prod[3] <= n1_vec[0] * n1_ups[2];
            r2_prod[4] <= n1_vec[0] * n1_ups[1];
            r2_prod[5] <= n1_vec[1] * n1_ups[0];
            r2_v       <= n1_vec;
            r3_ok      <= r2_ok;
            r3_c[0]    <= XW'(r2_prod[0] - r2_prod[1]);
            r3_c[1]    <= XW'(r2_prod[2] - r2_prod[3]);
            r3_c[2]    <= XW'(r2_prod[4] - r2_prod[5]);
            r3_v       <= r2_v;
        end
    end

    always_comb begin
        n2_ctl.en    = en;
        n2_ctl.valid = r3_valid;
        n2_side_in   = {r3_ok, r3_v[2], r3_v[1], r3_v[0]};
        for (int k = 0; k < 3; k++) begin
            n2_v[k] = $signed(n2_side[VW*k +: VW]);
        end
    end

    lacb_norm #(
        .IN_W   (XW),
        .FRAC_W (F),
        .SIDE_W (SIDE2W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n2_ctl),
        .i_vec   (r3_c),
        .i_side  (n2_side_in),
        .o_stat  (n2_stat),
        .o_vec   (n2_vec),
        .o_side  (n2_side)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok      <= n2_stat.ok && n2_side[SIDE2W-1];
            r4_prod[0] <= n2_vec[1] * n2_v[2];
            r4_prod[1] <= n2_vec[2] * n2_v[1];
            r4_prod[2] <= n2_vec[2] * n2_v[0];
            r4_prod[3] <= n2_vec[0] * n2_v[2];
            r4_prod[4] <= n2_vec[0] * n2_v[1];
            r4_prod[5] <= n2_vec[1] * n2_v[0];
            r4_v       <= n2_v;
            r4_s       <= n2_vec;
            r5_ok      <= r4_ok;
            r5_p[0]    <= PW'(r4_prod[0] - r4_prod[1]);
            r5_p[1]    <= PW'(r4_prod[2] - r4_prod[3]);
            r5_p[2]    <= PW'(r4_prod[4] - r4_prod[5]);
            r5_v       <= r4_v;
            r5_s       <= r4_s;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_pm[k] = r5_p[k][PW-1] ? PW'(-r5_p[k]) : PW'(r5_p[k]);
            o_pr[k] = (o_pm[k] + (PW'(1) << (F - 1))) >> F;
            if (o_pr[k] > (PW'(1) << F)) begin
                o_pr[k] = PW'(1) << F;
            end
            o_u[k]  = r5_p[k][PW-1] ? -$signed(VW'(o_pr[k])) : $signed(VW'(o_pr[k]));
            o_ev[k] = r5_v[k];
            o_es[k] = r5_s[k];
            o_eu[k] = o_u[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_fwd[k]   <= r5_ok ? o_ev[k][OW-1:0] : '0;
                r_side[k]  <= r5_ok ? o_es[k][OW-1:0] : '0;
                r_camup[k] <= r5_ok ? o_eu[k][OW-1:0] : '0;
            end
            r_degen <= !r5_ok;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.fwd_x      = r_fwd[0];
    assign o_res.fwd_y      = r_fwd[1];
    assign o_res.fwd_z      = r_fwd[2];
    assign o_res.side_x     = r_side[0];
    assign o_res.side_y     = r_side[1];
    assign o_res.side_z     = r_side[2];
    assign o_res.camup_x    = r_camup[0];
    assign o_res.camup_y    = r_camup[1];
    assign o_res.camup_z    = r_camup[2];
    assign o_res.degenerate = r_degen;

endmodule

>>> src/lacb_checker.sv
// ----------------------------------------------------------------------------
// lacb_checker: port-level checks of the look-at camera basis
// Watches the request and result channels and flags violations.
// ----------------------------------------------------------------------------
module lacb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_fwd_x,
    input logic [15:0] i_fwd_y,
    input logic [15:0] i_fwd_z,
    input logic [15:0] i_side_x,
    input logic [15:0] i_side_y,
    input logic [15:0] i_side_z,
    input logic [15:0] i_camup_x,
    input logic [15:0] i_camup_y,
    input logic [15:0] i_camup_z,
    input logic        i_degenerate
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Request refused while no result is pending.");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_degenerate) |->
        (i_fwd_x == 16'd0 && i_fwd_y == 16'd0 && i_fwd_z == 16'd0 &&
         i_side_x == 16'd0 && i_side_y == 16'd0 && i_side_z == 16'd0 &&
         i_camup_x == 16'd0 && i_camup_y == 16'd0 && i_camup_z == 16'd0))
        else $error("Degenerate result carries nonzero vectors.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_fwd_x) && $stable(i_side_y) &&
         $stable(i_camup_z) && $stable(i_degenerate)))
        else $error("Stalled result changed.");

endmodule

bind look_at_camera_basis lacb_checker u_lacb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_fwd_x      (o_res.fwd_x),
    .i_fwd_y      (o_res.fwd_y),
    .i_fwd_z      (o_res.fwd_z),
    .i_side_x     (o_res.side_x),
    .i_side_y     (o_res.side_y),
    .i_side_z     (o_res.side_z),
    .i_camup_x    (o_res.camup_x),
    .i_camup_y    (o_res.camup_y),
    .i_camup_z    (o_res.camup_z),
    .i_degenerate (o_res.degenerate)
);

>>> tb/tb_look_at_camera_basis.sv
// ----------------------------------------------------------------------------
// tb_look_at_camera_basis: self-checking bench of the look-at camera basis
// Drives directed and random camera set-ups, predicts forward, side and
// camera-up vectors in fixed point and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_look_at_camera_basis;
    import lacb_pkg::*;

    localparam int CW = LACB_COORD_WIDTH;
    localparam int FB = LACB_UNIT_FRAC_BITS;
    localparam int LATENCY = 81 + 2 * FB;
    localparam int N_RANDOM = 500;
    localparam longint ONE = 64'sd1 << FB;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [LACB_OUT_W-1:0] t_unit;

    typedef struct {
        t_coord eye[3];
        t_coord tgt[3];
        t_coord up[3];
    } t_setup;

    typedef struct {
        t_unit fwd[3];
        t_unit side[3];
        t_unit camup[3];
        logic  degenerate;
    } t_basis;

    typedef struct {
        t_setup req;
        bit     typed;
        t_basis res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit failed = 1'b0;
    bit no_idle = 1'b0;
    t_basis basis_q[$];
    t_basis pending_typed[$];

    lacb_in_if #(.COORD_W(CW)) req_if ();
    lacb_out_if res_if ();

    look_at_camera_basis dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned magnitude(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic bit scale_vec(input longint a[3], output longint r[3]);
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned v;
        int p;
        for (int i = 0; i < 3; i++) m[i] = magnitude(a[i]);
        top = m[0] | m[1] | m[2];
        if (top == 0) return 1'b0;
        p = 0;
        while (p < 63 && (top >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            v = p > 29 ? m[i] >> (p - 29) : m[i] << (29 - p);
            r[i] = a[i] < 0 ? -longint'(v) : longint'(v);
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input longint a[3], output longint u[3]);
        longint r[3];
        longint unsigned len2, len, q;
        if (!scale_vec(a, r)) return 1'b0;
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += magnitude(r[i]) * magnitude(r[i]);
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = ((magnitude(r[i]) << FB) + (len >> 1)) / len;
            if (q > ONE) q = ONE;
            u[i] = r[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_basis camera_basis(t_setup s);
        t_basis b;
        longint d[3], up[3], ups[3], v[3], c[3], sd[3], p[3];
        longint unsigned m;
        bit ok;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(s.tgt[i]) - longint'(s.eye[i]);
            up[i] = longint'(s.up[i]);
        end
        ok = unit_vec(d, v);
        if (ok) ok = scale_vec(up, ups);
        if (ok) begin
            cross_vec(v, ups, c);
            ok = unit_vec(c, sd);
        end
        b.degenerate = !ok;
        for (int i = 0; i < 3; i++) begin
            b.fwd[i] = '0;
            b.side[i] = '0;
            b.camup[i] = '0;
        end
        if (ok) begin
            cross_vec(sd, v, p);
            for (int i = 0; i < 3; i++) begin
                m = (magnitude(p[i]) + (64'd1 << (FB - 1))) >> FB;
                if (m > ONE) m = ONE;
                b.fwd[i] = t_unit'(v[i]);
                b.side[i] = t_unit'(sd[i]);
                b.camup[i] = p[i] < 0 ? t_unit'(-longint'(m)) : t_unit'(m);
            end
        end
        return b;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 2000)) - t_coord'(1000);
            2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            3: return t_coord'(1) <<< $urandom_range(0, CW - 2);
            default: return t_coord'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic t_setup rand_setup();
        t_setup s;
        for (int i = 0; i < 3; i++) begin
            s.eye[i] = rand_coord();
            s.tgt[i] = rand_coord();
            s.up[i] = rand_coord();
        end
        case ($urandom_range(0, 19))
            0: s.tgt = s.eye;
            1: s.up = '{0, 0, 0};
            2: for (int i = 0; i < 3; i++) s.up[i] = s.tgt[i] - s.eye[i];
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_setup mk(t_coord ex, t_coord ey, t_coord ez,
                                  t_coord tx, t_coord ty, t_coord tz,
                                  t_coord ux, t_coord uy, t_coord uz);
        t_setup s;
        s.eye = '{ex, ey, ez};
        s.tgt = '{tx, ty, tz};
        s.up = '{ux, uy, uz};
        return s;
    endfunction

    function automatic t_basis zero_basis();
        t_basis b;
        b.fwd = '{0, 0, 0};
        b.side = '{0, 0, 0};
        b.camup = '{0, 0, 0};
        b.degenerate = 1'b1;
        return b;
    endfunction

    function automatic t_basis axis_basis(t_unit f[3], t_unit sd[3], t_unit u[3]);
        t_basis b;
        b.fwd = f;
        b.side = sd;
        b.camup = u;
        b.degenerate = 1'b0;
        return b;
    endfunction

    task automatic send_setup(t_setup s);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        {req_if.eye_x, req_if.eye_y, req_if.eye_z} <= {s.eye[0], s.eye[1], s.eye[2]};
        {req_if.target_x, req_if.target_y, req_if.target_z} <= {s.tgt[0], s.tgt[1], s.tgt[2]};
        {req_if.upref_x, req_if.upref_y, req_if.upref_z} <= {s.up[0], s.up[1], s.up[2]};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic check_unit(string name, t_unit exp_v, t_unit act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_basis e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (basis_q.size() == 0) begin
                $error("result with no request outstanding");
                failed = 1'b1;
            end else begin
                e = basis_q.pop_front();
                check_unit("fwd_x", e.fwd[0], res_if.fwd_x);
                check_unit("fwd_y", e.fwd[1], res_if.fwd_y);
                check_unit("fwd_z", e.fwd[2], res_if.fwd_z);
                check_unit("side_x", e.side[0], res_if.side_x);
                check_unit("side_y", e.side[1], res_if.side_y);
                check_unit("side_z", e.side[2], res_if.side_z);
                check_unit("camup_x", e.camup[0], res_if.camup_x);
                check_unit("camup_y", e.camup[1], res_if.camup_y);
                check_unit("camup_z", e.camup[2], res_if.camup_z);
                if (e.degenerate !== res_if.degenerate) begin
                    $error("degenerate: expected %0d, got %0d", e.degenerate,
                           res_if.degenerate);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_setup s;
        if (req_if.valid && req_if.ready && i_rst_n) begin
            s = mk(req_if.eye_x, req_if.eye_y, req_if.eye_z,
                   req_if.target_x, req_if.target_y, req_if.target_z,
                   req_if.upref_x, req_if.upref_y, req_if.upref_z);
            if (pending_typed.size() != 0) begin
                basis_q.push_back(pending_typed.pop_front());
            end else begin
                basis_q.push_back(camera_basis(s));
            end
        end
    end

    localparam t_coord MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord MINC = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord Q1 = t_coord'(1) <<< 16;

    initial begin
        t_row rows[$];
        t_row r;
        t_setup s;
        int wait_cnt;
        req_if.valid = 1'b0;
        {req_if.eye_x, req_if.eye_y, req_if.eye_z} = '0;
        {req_if.target_x, req_if.target_y, req_if.target_z} = '0;
        {req_if.upref_x, req_if.upref_y, req_if.upref_z} = '0;
        res_if.ready = 1'b0;

        // Looking down minus z with y up gives side +x and camera up +y.
        rows.push_back('{mk(0, 0, 0, 0, 0, -Q1, 0, Q1, 0), 1'b1,
            axis_basis('{0, 0, -16384}, '{16384, 0, 0}, '{0, 16384, 0})});
        rows.push_back('{mk(0, 0, 0, Q1, 0, 0, 0, Q1, 0), 1'b1,
            axis_basis('{16384, 0, 0}, '{0, 0, 16384}, '{0, 16384, 0})});
        rows.push_back('{mk(Q1, Q1, Q1, Q1, Q1, Q1, 0, Q1, 0), 1'b1, zero_basis()});
        rows.push_back('{mk(MAXC, MINC, MAXC, MAXC, MINC, MAXC, 1, 1, 1), 1'b1, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 0, 0, -Q1, 0, 0, 0), 1'b1, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 0, Q1, 0, 0, Q1, 0), 1'b1, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 0, MAXC, 0, 0, MINC, 0), 1'b1, zero_basis()});
        rows.push_back('{mk(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC), 1'b0, zero_basis()});
        rows.push_back('{mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC), 1'b0, zero_basis()});
        rows.push_back('{mk(MINC, 0, 0, MAXC, 0, 0, 0, MAXC, 0), 1'b0, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 1, 0, 0, 0, 0, 1), 1'b0, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 1, 1, 1, -1, 0, 1), 1'b0, zero_basis()});
        rows.push_back('{mk(-1, -1, -1, 0, 0, 0, MINC, MINC, MAXC), 1'b0, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 3, 4, 0, 0, 0, -1), 1'b0, zero_basis()});
        rows.push_back('{mk(0, 0, 0, 5, 5, 5, 1, 1, 2), 1'b0, zero_basis()});
        rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1, zero_basis()});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            if (r.typed) pending_typed.push_back(r.res);
            else pending_typed.push_back(camera_basis(r.req));
            send_setup(r.req);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 150 && n < 230);
            if (n == 300) begin
                req_if.valid <= 1'b0;
                while (basis_q.size() != 0 || pending_typed.size() != 0) @(posedge i_clk);
            end
            s = rand_setup();
            pending_typed.push_back(camera_basis(s));
            send_setup(s);
        end
        req_if.valid <= 1'b0;
        no_idle = 1'b0;

        wait_cnt = 0;
        while (basis_q.size() != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (!failed && basis_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (basis_q.size() != 0) $error("%0d results never arrived", basis_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
